>>> hdl/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// lrupr_pkg
// shared constants and types for the lru page replacement block
// ----------------------------------------------------------------------------
package lrupr_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int PAGE_BITS_DEF   = 16;
  localparam int CFG_W           = 5;
  localparam int OCC_W           = 5;
  localparam int ACTIVE_RESET    = 16;

  // per-reference status from the stack to the top level
  typedef struct packed {
    logic hit;
    logic evict;
  } lrupr_ref_t;

endpackage

>>> hdl/lrupr_stack.sv
// ----------------------------------------------------------------------------
// lrupr_stack
// recency-ordered page stack: parallel match, move-to-front and eviction
// ----------------------------------------------------------------------------
module lrupr_stack import lrupr_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int PAGE_BITS   = PAGE_BITS_DEF,
  localparam int CNT_W      = $clog2(MAX_ENTRIES + 1),
  localparam int IDX_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 ref_en,
  input  logic [PAGE_BITS-1:0] ref_page,
  input  logic [CNT_W-1:0]     cap,
  output lrupr_ref_t           stat,
  output logic [PAGE_BITS-1:0] evict_page,
  output logic [CNT_W-1:0]     occ_nxt
);

  logic [PAGE_BITS-1:0]   pages_r [MAX_ENTRIES];
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_nxt;
  logic [MAX_ENTRIES-1:0] hit_vec;
  logic [MAX_ENTRIES-1:0] upper;
  logic [CNT_W-1:0]       last_pos;
  logic [IDX_W-1:0]       evict_idx;
  logic                   hit;
  logic                   evict;

  // match against every held entry
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_vec[i] = (count_r > CNT_W'(i)) && (pages_r[i] == ref_page);
    end
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      upper[i] = |(hit_vec >> i);
    end
  end

  assign hit       = |hit_vec;
  assign evict     = !hit && (count_r >= cap);
  assign last_pos  = count_r - CNT_W'(1);
  assign evict_idx = last_pos[IDX_W-1:0];

  always_comb begin
    if (hit || evict) begin
      count_nxt = count_r;
    end else begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  assign stat.hit   = hit;
  assign stat.evict = evict;
  assign evict_page = evict ? pages_r[evict_idx] : '0;
  assign occ_nxt    = count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ref_en) begin
      count_r <= count_nxt;
    end
  end

  // on a hit shift only up to the matching slot, on a miss shift everything
  always_ff @(posedge clk) begin
    if (ref_en) begin
      pages_r[0] <= ref_page;
      for (int i = 1; i < MAX_ENTRIES; i++) begin
        if (!hit || upper[i]) begin
          pages_r[i] <= pages_r[i-1];
        end
      end
    end
  end

endmodule

>>> hdl/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement
// lru page stack with move-to-front on hit and lru eviction on miss
// ----------------------------------------------------------------------------
// a result passes the input and result registers, then strobes on out_valid
// throughput: one reference per cycle, busy never rises; the parallel compare
//   and shift of the page stack sets that figure
// reset: synchronous active-low rst_n empties the stack, sets active_entries
//   to 16 and rearms the capacity latch; the receiver cannot stall results
module lru_page_replacement import lrupr_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int PAGE_BITS   = PAGE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // reference input
  input  logic                 start,
  output logic                 busy,
  input  logic [PAGE_BITS-1:0] in_page_number,
  // result
  output logic                 out_valid,
  output logic                 out_hit,
  output logic                 out_evicted_valid,
  output logic [PAGE_BITS-1:0] out_evicted_page,
  output logic [OCC_W-1:0]     out_occupancy
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  logic [CFG_W-1:0]     cfg_r;
  logic                 in_vld_r;
  logic [PAGE_BITS-1:0] in_page_r;
  logic                 cap_taken_r;
  logic [CNT_W-1:0]     cap_r;
  logic [CNT_W-1:0]     cap_sat;
  logic [CNT_W-1:0]     cap_eff;
  lrupr_ref_t           stat;
  logic [PAGE_BITS-1:0] evict_page;
  logic [CNT_W-1:0]     occ_nxt;
  logic                 out_valid_r;
  logic                 out_hit_r;
  logic                 out_evict_r;
  logic [PAGE_BITS-1:0] out_page_r;
  logic [CNT_W-1:0]     occ_r;

  // every cycle takes a reference, so the input side never holds off
  assign busy = 1'b0;

  // capacity register, clamped to 1..MAX_ENTRIES
  always_comb begin
    if (cfg_r == '0) begin
      cap_sat = CNT_W'(1);
    end else if (int'(cfg_r) > MAX_ENTRIES) begin
      cap_sat = CNT_W'(MAX_ENTRIES);
    end else begin
      cap_sat = CNT_W'(cfg_r);
    end
  end

  // capacity is frozen at the first reference after reset
  assign cap_eff = cap_taken_r ? cap_r : cap_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CFG_W'(ACTIVE_RESET);
      in_vld_r    <= 1'b0;
      cap_taken_r <= 1'b0;
      cap_r       <= CNT_W'(MAX_ENTRIES);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      in_vld_r    <= start && !busy;
      out_valid_r <= in_vld_r;
      if (in_vld_r) begin
        cap_taken_r <= 1'b1;
        cap_r       <= cap_eff;
      end
    end
  end

  // input register: page of the reference being resolved next cycle
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_page_r <= in_page_number;
    end
  end

  lrupr_stack #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .PAGE_BITS   (PAGE_BITS)
  ) u_stack (
    .clk        (clk),
    .rst_n      (rst_n),
    .ref_en     (in_vld_r),
    .ref_page   (in_page_r),
    .cap        (cap_eff),
    .stat       (stat),
    .evict_page (evict_page),
    .occ_nxt    (occ_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      out_hit_r   <= stat.hit;
      out_evict_r <= stat.evict;
      out_page_r  <= evict_page;
      occ_r       <= occ_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_evicted_valid = out_evict_r;
  assign out_evicted_page  = out_page_r;
  assign out_occupancy     = OCC_W'(occ_r);

`ifndef SYNTHESIS
  // every start transfer yields a result after the input and result registers
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("result strobe missing after start transfer");

  // stack never holds more pages than the latched capacity
  a_occ_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (occ_r <= cap_r))
    else $error("occupancy above capacity");

  // eviction only on a miss with the stack full
  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evicted_valid) |-> (!out_hit && occ_r == cap_r))
    else $error("eviction without full stack");
`endif

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the lru page replacement block: page references are
// driven in random bursts, each transfer is run through a local lru stack
// model and the strobed result is compared field by field in order
// ----------------------------------------------------------------------------
module tb import lrupr_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PW          = PAGE_BITS_DEF;
  localparam int DEPTH       = MAX_ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SHOW_MAX    = 10;

  // one predicted result per page reference
  typedef struct packed {
    logic           hit;
    logic           evicted_valid;
    logic [PW-1:0]  evicted_page;
    logic [OCC_W-1:0] occupancy;
  } ref_status_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             start = 1'b0;
  logic             busy;
  logic [PW-1:0]    in_page_number = '0;
  logic             out_valid;
  logic             out_hit;
  logic             out_evicted_valid;
  logic [PW-1:0]    out_evicted_page;
  logic [OCC_W-1:0] out_occupancy;

  // page references waiting to be driven, and results predicted but not yet seen
  logic [PW-1:0] pending_refs[$];
  ref_status_t   predicted_status[$];

  // local copy of the lru stack: position 0 is most recent, held entries are
  // contiguous from position 0
  logic [PW-1:0]    stack_page[DEPTH];
  int               held;
  logic [CFG_W-1:0] active_entries_shadow;
  int               capacity;
  bit               capacity_latched;

  int mismatches;
  int cycle_count;
  int ref_count;
  int burst_left;
  int gap_left;

  always #2 clk = ~clk;

  lru_page_replacement i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .start            (start),
    .busy             (busy),
    .in_page_number   (in_page_number),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_evicted_valid(out_evicted_valid),
    .out_evicted_page (out_evicted_page),
    .out_occupancy    (out_occupancy)
  );

  // lru stack update for one reference, returns the status the block reports
  function automatic ref_status_t lru_reference(logic [PW-1:0] page);
    ref_status_t st;
    int          pos;
    int          c;
    bit          found;
    st = '0;
    pos = 0;
    found = 1'b0;
    // the capacity is taken from the register at the first reference only
    if (!capacity_latched) begin
      c = active_entries_shadow;
      if (c < 1) c = 1;
      if (c > DEPTH) c = DEPTH;
      capacity = c;
      capacity_latched = 1'b1;
    end
    for (int i = 0; i < held; i++) begin
      if (!found && stack_page[i] == page) begin
        found = 1'b1;
        pos = i;
      end
    end
    if (found) begin
      // move to front, newer entries slide down one slot
      st.hit = 1'b1;
      for (int i = pos; i > 0; i--) stack_page[i] = stack_page[i-1];
      stack_page[0] = page;
    end else begin
      // full stack drops its least recent page before the push
      if (held >= capacity && held > 0) begin
        st.evicted_valid = 1'b1;
        st.evicted_page = stack_page[held-1];
        held--;
      end
      for (int i = held; i > 0; i--) stack_page[i] = stack_page[i-1];
      stack_page[0] = page;
      held++;
    end
    st.occupancy = held[OCC_W-1:0];
    return st;
  endfunction

  function automatic void report_mismatch(string msg);
    mismatches++;
    if (mismatches <= SHOW_MAX) $display("mismatch: %s", msg);
  endfunction

  // driver: bursts of back-to-back transfers with random gaps, inputs move on
  // the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_refs.size() > 0) begin
      start <= 1'b1;
      in_page_number <= pending_refs[0];
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        // a quarter of the bursts run straight into the next one
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: config shadow, prediction on each accepted transfer, result check
  always @(posedge clk) begin
    ref_status_t exp_st;
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL lru_page_replacement");
      $finish;
    end else if (!rst_n) begin
      held = 0;
      active_entries_shadow = CFG_W'(ACTIVE_RESET);
      capacity = DEPTH;
      capacity_latched = 1'b0;
    end else begin
      if (out_valid) begin
        if (predicted_status.size() == 0) begin
          report_mismatch("result strobe with no reference outstanding");
        end else begin
          exp_st = predicted_status.pop_front();
          if (out_hit !== exp_st.hit || out_evicted_valid !== exp_st.evicted_valid ||
              out_evicted_page !== exp_st.evicted_page ||
              out_occupancy !== exp_st.occupancy)
            report_mismatch($sformatf(
              "hit %b/%b evicted_valid %b/%b evicted_page %h/%h occupancy %0d/%0d (exp/got)",
              exp_st.hit, out_hit, exp_st.evicted_valid, out_evicted_valid,
              exp_st.evicted_page, out_evicted_page, exp_st.occupancy, out_occupancy));
        end
      end
      if (start && !busy) begin
        predicted_status.push_back(lru_reference(in_page_number));
        void'(pending_refs.pop_front());
        ref_count++;
      end
      // register write lands on this edge, only seen by the next reference
      if (cfg_we) active_entries_shadow = cfg_wdata;
    end
  end

  // hold until nothing is queued or outstanding, then let the pipe drain
  task automatic wait_idle();
    while (pending_refs.size() > 0 || predicted_status.size() > 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_active_entries(logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // random references: mostly drawn from a small working set so hits, fills
  // and evictions all occur, with some full-range noise
  task automatic queue_random_refs(int count);
    logic [PW-1:0] working_set[$];
    int            set_size;
    int            mode;
    int            run_len;
    int            scan_pos;
    int            made;
    logic [PW-1:0] page;
    set_size = $urandom_range(1, capacity + 4);
    for (int i = 0; i < set_size; i++) begin
      case ($urandom_range(0, 9))
        0: working_set.push_back('0);
        1: working_set.push_back('1);
        default: working_set.push_back(PW'($urandom));
      endcase
    end
    made = 0;
    scan_pos = 0;
    while (made < count) begin
      mode = $urandom_range(0, 9);
      run_len = $urandom_range(4, 24);
      page = working_set[$urandom_range(0, set_size - 1)];
      for (int k = 0; k < run_len && made < count; k++) begin
        if (mode < 4) begin
          // random pick from the working set
          pending_refs.push_back(working_set[$urandom_range(0, set_size - 1)]);
        end else if (mode < 7) begin
          // cyclic scan, the classic lru worst case once the set exceeds capacity
          pending_refs.push_back(working_set[scan_pos % set_size]);
          scan_pos++;
        end else if (mode < 9) begin
          // locality: one page hammered with the odd neighbor
          pending_refs.push_back(($urandom_range(0, 2) == 0) ?
                                 working_set[$urandom_range(0, set_size - 1)] : page);
        end else begin
          pending_refs.push_back(PW'($urandom));
        end
        made++;
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] first_cap;
    logic [CFG_W-1:0] later_cfg[5];
    mismatches = 0;
    cycle_count = 0;
    ref_count = 0;
    burst_left = 1;
    gap_left = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // before the first reference: only the last write counts, out-of-range
    // values clamp to 1 and to the full depth
    case ($urandom_range(0, 9))
      0: first_cap = '0;
      1: first_cap = '1;
      2: first_cap = CFG_W'(1);
      3: first_cap = CFG_W'(DEPTH);
      default: first_cap = CFG_W'($urandom_range(2, DEPTH - 1));
    endcase
    write_active_entries('1);
    write_active_entries('0);
    write_active_entries(first_cap);
    repeat (2) @(negedge clk);

    // directed: extreme page numbers, repeat hits, then a fill past any capacity
    pending_refs.push_back('0);
    pending_refs.push_back('1);
    pending_refs.push_back('0);
    pending_refs.push_back('1);
    pending_refs.push_back(PW'(16'hAAAA));
    pending_refs.push_back(PW'(16'h5555));
    for (int p = 1; p <= DEPTH; p++) pending_refs.push_back(PW'(p));
    pending_refs.push_back(PW'(1));
    pending_refs.push_back(PW'(DEPTH));
    wait_idle();

    // later writes are stored but the latched capacity holds until reset
    later_cfg[0] = CFG_W'(1);
    later_cfg[1] = '1;
    later_cfg[2] = '0;
    later_cfg[3] = CFG_W'(DEPTH);
    later_cfg[4] = CFG_W'($urandom);
    for (int ph = 0; ph < 5; ph++) begin
      queue_random_refs(150);
      wait_idle();
      write_active_entries(later_cfg[ph]);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && predicted_status.size() == 0) begin
      $display("PASS lru_page_replacement");
    end else begin
      $display("FAIL lru_page_replacement");
    end
    $finish;
  end

endmodule
